### hdl/rccm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and modular helpers for the restricted composition counter.
// Used by every module of the block; depends on nothing.
package rccm_pkg;

  localparam int MAX_PART = 64;
  localparam int VAL_W = 30;
  localparam int SUM_W = 60;
  localparam int MASK_W = 64;
  localparam int CFG_IDX_W = 8;
  localparam int DRAIN_CYC = 7;

  localparam logic [VAL_W-1:0] MODULUS = 30'd1000000007;
  // floor(2^60 / MODULUS), the Barrett reciprocal.
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_SET = 8'd1;

  typedef struct packed {
    logic first;
    logic last;
  } mac_ctl_t;

  function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

### hdl/rccm_modmul.sv
`timescale 1ns / 1ps
// Four-stage modular multiplier with Barrett reduction and a passed-through control tag.
// Depends on rccm_pkg.
module rccm_modmul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_v,
  input  rccm_pkg::mac_ctl_t              in_ctl,
  input  logic [rccm_pkg::VAL_W-1:0]      in_a,
  input  logic [rccm_pkg::VAL_W-1:0]      in_b,
  output logic                            out_v,
  output rccm_pkg::mac_ctl_t              out_ctl,
  output logic [rccm_pkg::VAL_W-1:0]      out_r
);

  logic [3:0] v_r;
  rccm_pkg::mac_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r;
  logic [59:0] prod_r;
  logic [61:0] q2_r;
  logic [31:0] lo2_r;
  logic [31:0] rem_r;
  logic [rccm_pkg::VAL_W-1:0] res_r;
  logic [60:0] qp;
  logic [31:0] rem_nxt;
  logic [31:0] red;

  assign qp = q2_r[61:31] * rccm_pkg::MODULUS;
  assign rem_nxt = lo2_r - qp[31:0];

  always_comb begin
    red = rem_r;
    if (rem_r >= {1'b0, rccm_pkg::MODULUS, 1'b0}) begin
      red = rem_r - {1'b0, rccm_pkg::MODULUS, 1'b0};
    end else if (rem_r >= {2'b00, rccm_pkg::MODULUS}) begin
      red = rem_r - {2'b00, rccm_pkg::MODULUS};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_v};
    end
    ctl1_r <= in_ctl;
    ctl2_r <= ctl1_r;
    ctl3_r <= ctl2_r;
    ctl4_r <= ctl3_r;
    prod_r <= in_a * in_b;
    q2_r <= prod_r[59:29] * rccm_pkg::BARRETT_MU;
    lo2_r <= prod_r[31:0];
    rem_r <= rem_nxt;
    res_r <= red[rccm_pkg::VAL_W-1:0];
  end

  assign out_v = v_r[3];
  assign out_ctl = ctl4_r;
  assign out_r = res_r;

endmodule

### hdl/rccm_matmem.sv
`timescale 1ns / 1ps
// Matrix store: one write port and two registered read ports.
// Depends on rccm_pkg.
module rccm_matmem #(
  parameter int AW = 14,
  parameter int DEPTH = 12288
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [rccm_pkg::VAL_W-1:0]      wdata,
  input  logic [AW-1:0]                   raddr_a,
  input  logic [AW-1:0]                   raddr_b,
  output logic [rccm_pkg::VAL_W-1:0]      rdata_a,
  output logic [rccm_pkg::VAL_W-1:0]      rdata_b
);

  logic [rccm_pkg::VAL_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/restricted_composition_count_mod.sv
`timescale 1ns / 1ps
// Restricted composition counter modulo 1000000007: sequencer, term store and accumulator.
// Depends on rccm_pkg, rccm_modmul and rccm_matmem.
//
// One item is worked at a time; busy stays high from the accepting edge until the result
// strobe, and the receiver cannot stall: out_valid is high for one cycle with out_way_count.
// With L the largest allowed part, an item builds the terms and, for n above L, sets up
// the matrices and runs matrix products: one squaring per bit of n-L below its top bit
// plus one product per set bit of n-L. The matrix products run through a single pipelined
// modular multiplier fed by the two read ports of the matrix memory; the final dot product
// pairs read port A with the term store. The multiply-accumulate count sets the run time.
module restricted_composition_count_mod #(
  parameter int MAX_PART = rccm_pkg::MAX_PART
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rccm_pkg::SUM_W-1:0]        in_target_sum,
  output logic                              out_valid,
  output logic [rccm_pkg::VAL_W-1:0]        out_way_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rccm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rccm_pkg::MASK_W-1:0]       cfg_data
);

  localparam int PW = (MAX_PART > 1) ? $clog2(MAX_PART) : 1;
  localparam int TW = $clog2(MAX_PART + 1);
  localparam int AW = 2 + 2 * PW;
  localparam int DEPTH = 3 * (1 << (2 * PW));
  localparam int VW = rccm_pkg::VAL_W;
  localparam int SW = rccm_pkg::SUM_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_TRD  = 4'd2;
  localparam logic [3:0] S_TWR  = 4'd3;
  localparam logic [3:0] S_DEC  = 4'd4;
  localparam logic [3:0] S_RES  = 4'd5;
  localparam logic [3:0] S_INIT = 4'd6;
  localparam logic [3:0] S_STA  = 4'd7;
  localparam logic [3:0] S_STB  = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_MDR  = 4'd10;
  localparam logic [3:0] S_DOT  = 4'd11;
  localparam logic [3:0] S_DDR  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  localparam logic [1:0] BANK0 = 2'd0;
  localparam logic [1:0] BANK1 = 2'd1;
  localparam logic [1:0] BANK2 = 2'd2;

  logic [rccm_pkg::MASK_W-1:0] mask1_r, mask2_r;
  logic [MAX_PART-1:0] allowed;

  logic [3:0] state_r, state_nxt;
  logic [SW-1:0] n_r, n_nxt;
  logic [SW-1:0] e_r, e_nxt;
  logic [TW-1:0] top_r, top_nxt, tk_r, tk_nxt, ti_r, ti_nxt;
  logic [TW-1:0] top_m1, tk_m1;
  logic [VW-1:0] tacc_r, tacc_nxt;
  logic trd_v_r, trd_v_nxt, tbit_r, tbit_nxt;
  logic [VW-1:0] tsum;

  logic [VW-1:0] terms [0:MAX_PART];
  logic [VW-1:0] t_rdata_r;
  logic t_we;
  logic [TW-1:0] t_waddr, t_raddr;
  logic [VW-1:0] t_wdata;

  logic [1:0] b_acc_r, b_acc_nxt, b_pow_r, b_pow_nxt, b_free_r, b_free_nxt;
  logic kind_r, kind_nxt;
  logic dot_r, dot_nxt;
  logic ph_r, ph_nxt;
  logic [PW-1:0] r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic [PW-1:0] wr_r_r, wr_r_nxt, wr_c_r, wr_c_nxt;
  logic [2:0] drain_r, drain_nxt;
  logic r_last, c_last, k_last;

  logic iss_v_r, iss_v_nxt;
  rccm_pkg::mac_ctl_t iss_ctl_r, iss_ctl_nxt;

  logic m_we_init;
  logic [AW-1:0] m_waddr, m_raddr_a, m_raddr_b, init_addr;
  logic [VW-1:0] m_wdata, init_data, m_rdata_a, m_rdata_b;

  logic mo_v;
  rccm_pkg::mac_ctl_t mo_ctl;
  logic [VW-1:0] mo_r, msum, macc_r, macc_nxt;
  logic acc_wr;

  logic [VW-1:0] result_r, result_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [1:0] lhs_bank, rhs_bank;
  logic pow_one;

  assign allowed = mask1_r[MAX_PART-1:0] & mask2_r[MAX_PART-1:0];
  assign top_m1 = top_r - 1'b1;
  assign tk_m1 = tk_r - 1'b1;
  assign r_last = (TW'(r_r) == top_m1);
  assign c_last = (TW'(c_r) == top_m1);
  assign k_last = (TW'(k_r) == top_m1);
  assign tsum = (trd_v_r && tbit_r) ? rccm_pkg::mod_add(tacc_r, t_rdata_r) : tacc_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask1_r <= '0;
      mask2_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == rccm_pkg::REG_FIRST_SET) begin
        mask1_r <= cfg_data;
      end else if (cfg_index == rccm_pkg::REG_SECOND_SET) begin
        mask2_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      terms[t_waddr] <= t_wdata;
    end
    t_rdata_r <= terms[t_raddr];
  end

  assign lhs_bank = kind_r ? b_pow_r : b_acc_r;
  assign rhs_bank = b_pow_r;

  always_comb begin
    pow_one = 1'b0;
    if (r_last) begin
      pow_one = allowed[top_m1[PW-1:0] - c_r];
    end else if ((TW'(r_r) + 1'b1) == TW'(c_r)) begin
      pow_one = 1'b1;
    end
    if (ph_r) begin
      init_addr = {b_acc_r, r_r, c_r};
      init_data = (r_r == c_r) ? VW'(1) : '0;
    end else begin
      init_addr = {b_pow_r, r_r, c_r};
      init_data = pow_one ? VW'(1) : '0;
    end
  end

  assign m_we_init = (state_r == S_INIT);
  assign acc_wr = mo_v && mo_ctl.last && !dot_r;
  assign msum = mo_ctl.first ? mo_r : rccm_pkg::mod_add(macc_r, mo_r);
  assign m_waddr = m_we_init ? init_addr : {b_free_r, wr_r_r, wr_c_r};
  assign m_wdata = m_we_init ? init_data : msum;

  always_comb begin
    if (state_r == S_DOT) begin
      m_raddr_a = {b_acc_r, top_m1[PW-1:0], k_r};
    end else begin
      m_raddr_a = {lhs_bank, r_r, k_r};
    end
    m_raddr_b = {rhs_bank, k_r, c_r};
  end

  rccm_matmem #(
    .AW(AW),
    .DEPTH(DEPTH)
  ) u_matmem (
    .clk(clk),
    .we(m_we_init | acc_wr),
    .waddr(m_waddr),
    .wdata(m_wdata),
    .raddr_a(m_raddr_a),
    .raddr_b(m_raddr_b),
    .rdata_a(m_rdata_a),
    .rdata_b(m_rdata_b)
  );

  rccm_modmul u_modmul (
    .clk(clk),
    .rst_n(rst_n),
    .in_v(iss_v_r),
    .in_ctl(iss_ctl_r),
    .in_a(m_rdata_a),
    .in_b(dot_r ? t_rdata_r : m_rdata_b),
    .out_v(mo_v),
    .out_ctl(mo_ctl),
    .out_r(mo_r)
  );

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r;
    e_nxt = e_r;
    top_nxt = top_r;
    tk_nxt = tk_r;
    ti_nxt = ti_r;
    tacc_nxt = tacc_r;
    trd_v_nxt = 1'b0;
    tbit_nxt = tbit_r;
    t_we = 1'b0;
    t_waddr = ti_r;
    t_wdata = tsum;
    t_raddr = ti_r - tk_r;
    b_acc_nxt = b_acc_r;
    b_pow_nxt = b_pow_r;
    b_free_nxt = b_free_r;
    kind_nxt = kind_r;
    dot_nxt = dot_r;
    ph_nxt = ph_r;
    r_nxt = r_r;
    c_nxt = c_r;
    k_nxt = k_r;
    wr_r_nxt = wr_r_r;
    wr_c_nxt = wr_c_r;
    drain_nxt = drain_r;
    iss_v_nxt = 1'b0;
    iss_ctl_nxt = iss_ctl_r;
    macc_nxt = macc_r;
    result_nxt = result_r;
    out_valid_nxt = 1'b0;

    if (mo_v) begin
      macc_nxt = msum;
      if (mo_ctl.last) begin
        if (dot_r) begin
          result_nxt = msum;
        end else if (TW'(wr_c_r) == top_m1) begin
          wr_c_nxt = '0;
          wr_r_nxt = wr_r_r + 1'b1;
        end else begin
          wr_c_nxt = wr_c_r + 1'b1;
        end
      end
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          n_nxt = in_target_sum;
          t_we = 1'b1;
          t_waddr = '0;
          t_wdata = VW'(1);
          top_nxt = '0;
          tk_nxt = TW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (allowed[tk_m1[PW-1:0]]) begin
          top_nxt = tk_r;
        end
        if (tk_r == TW'(MAX_PART)) begin
          ti_nxt = TW'(1);
          tk_nxt = TW'(1);
          tacc_nxt = '0;
          if (allowed[tk_m1[PW-1:0]]) begin
            state_nxt = S_TRD;
          end else begin
            state_nxt = (top_r == '0) ? S_DEC : S_TRD;
          end
        end else begin
          tk_nxt = tk_r + 1'b1;
        end
      end
      S_TRD: begin
        tacc_nxt = tsum;
        trd_v_nxt = 1'b1;
        tbit_nxt = allowed[tk_m1[PW-1:0]];
        if (tk_r == ti_r) begin
          state_nxt = S_TWR;
        end else begin
          tk_nxt = tk_r + 1'b1;
        end
      end
      S_TWR: begin
        t_we = 1'b1;
        tacc_nxt = '0;
        tk_nxt = TW'(1);
        if (ti_r == top_r) begin
          state_nxt = S_DEC;
        end else begin
          ti_nxt = ti_r + 1'b1;
          state_nxt = S_TRD;
        end
      end
      S_DEC: begin
        t_raddr = n_r[TW-1:0];
        b_acc_nxt = BANK0;
        b_pow_nxt = BANK1;
        b_free_nxt = BANK2;
        r_nxt = '0;
        c_nxt = '0;
        ph_nxt = 1'b0;
        dot_nxt = 1'b0;
        e_nxt = n_r - SW'(top_r);
        if (n_r <= SW'(top_r)) begin
          state_nxt = S_RES;
        end else if (top_r == '0) begin
          result_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_RES: begin
        result_nxt = t_rdata_r;
        state_nxt = S_DONE;
      end
      S_INIT: begin
        ph_nxt = !ph_r;
        if (ph_r) begin
          if (c_last) begin
            c_nxt = '0;
            if (r_last) begin
              r_nxt = '0;
              state_nxt = S_STA;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end
      S_STA: begin
        r_nxt = '0;
        c_nxt = '0;
        k_nxt = '0;
        wr_r_nxt = '0;
        wr_c_nxt = '0;
        if (e_r == '0) begin
          dot_nxt = 1'b1;
          state_nxt = S_DOT;
        end else if (e_r[0]) begin
          kind_nxt = 1'b0;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_STB;
        end
      end
      S_STB: begin
        e_nxt = e_r >> 1;
        r_nxt = '0;
        c_nxt = '0;
        k_nxt = '0;
        wr_r_nxt = '0;
        wr_c_nxt = '0;
        if ((e_r >> 1) != '0) begin
          kind_nxt = 1'b1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_STA;
        end
      end
      S_MUL: begin
        iss_v_nxt = 1'b1;
        iss_ctl_nxt.first = (k_r == '0);
        iss_ctl_nxt.last = k_last;
        if (k_last) begin
          k_nxt = '0;
          if (c_last) begin
            c_nxt = '0;
            if (r_last) begin
              r_nxt = '0;
              drain_nxt = 3'(rccm_pkg::DRAIN_CYC);
              state_nxt = S_MDR;
            end else begin
              r_nxt = r_r + 1'b1;
            end
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_MDR: begin
        if (drain_r == '0) begin
          b_free_nxt = kind_r ? b_pow_r : b_acc_r;
          if (kind_r) begin
            b_pow_nxt = b_free_r;
            state_nxt = S_STA;
          end else begin
            b_acc_nxt = b_free_r;
            state_nxt = S_STB;
          end
        end else begin
          drain_nxt = drain_r - 1'b1;
        end
      end
      S_DOT: begin
        t_raddr = TW'(k_r) + 1'b1;
        iss_v_nxt = 1'b1;
        iss_ctl_nxt.first = (k_r == '0);
        iss_ctl_nxt.last = k_last;
        if (k_last) begin
          k_nxt = '0;
          drain_nxt = 3'(rccm_pkg::DRAIN_CYC);
          state_nxt = S_DDR;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_DDR: begin
        if (drain_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          drain_nxt = drain_r - 1'b1;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        dot_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      iss_v_r <= 1'b0;
      trd_v_r <= 1'b0;
      out_valid_r <= 1'b0;
      dot_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iss_v_r <= iss_v_nxt;
      trd_v_r <= trd_v_nxt;
      out_valid_r <= out_valid_nxt;
      dot_r <= dot_nxt;
    end
    n_r <= n_nxt;
    e_r <= e_nxt;
    top_r <= top_nxt;
    tk_r <= tk_nxt;
    ti_r <= ti_nxt;
    tacc_r <= tacc_nxt;
    tbit_r <= tbit_nxt;
    b_acc_r <= b_acc_nxt;
    b_pow_r <= b_pow_nxt;
    b_free_r <= b_free_nxt;
    kind_r <= kind_nxt;
    ph_r <= ph_nxt;
    r_r <= r_nxt;
    c_r <= c_nxt;
    k_r <= k_nxt;
    wr_r_r <= wr_r_nxt;
    wr_c_r <= wr_c_nxt;
    drain_r <= drain_nxt;
    iss_ctl_r <= iss_ctl_nxt;
    macc_r <= macc_nxt;
    result_r <= result_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_way_count = result_r;

endmodule

### bench/restricted_composition_count_mod_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for restricted_composition_count_mod: directed table, then random items.
// Depends on rccm_pkg and the block; expected counts: table entries or a matrix-power predictor.
module restricted_composition_count_mod_tb;

  localparam longint unsigned PRIME = 64'd1000000007;
  localparam int LIMIT_CYC = 20000000;
  localparam int N_RANDOM = 80;
  localparam int SW = rccm_pkg::SUM_W;
  localparam int MW = rccm_pkg::MASK_W;
  localparam int VW = rccm_pkg::VAL_W;
  localparam int IW = rccm_pkg::CFG_IDX_W;
  localparam int MAXP = rccm_pkg::MAX_PART;
  localparam logic [SW-1:0] SUM_MAX = {SW{1'b1}};
  localparam logic [MW-1:0] ALL_ONES = {MW{1'b1}};

  typedef struct {
    logic [MW-1:0] first_mask;
    logic [MW-1:0] second_mask;
    logic [SW-1:0] target;
    bit            known;
    logic [VW-1:0] ways;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [SW-1:0] in_target_sum = '0;
  logic out_valid;
  logic [VW-1:0] out_way_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [MW-1:0] cfg_data = '0;

  logic [MW-1:0] first_shadow = '0;
  logic [MW-1:0] second_shadow = '0;
  logic [VW-1:0] pending_ways[$];
  int errors = 0;
  int items_sent = 0;
  int counts_seen = 0;
  int reg_writes = 0;
  longint cycles = 0;
  row_t plan[$];

  restricted_composition_count_mod dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_target_sum(in_target_sum), .out_valid(out_valid), .out_way_count(out_way_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("restricted_composition_count_mod_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [VW-1:0] count_ways(input logic [MW-1:0] m1,
                                               input logic [MW-1:0] m2,
                                               input logic [SW-1:0] n);
    logic [MW-1:0] parts;
    longint unsigned terms[MAXP+1];
    longint unsigned pw[MAXP][MAXP];
    longint unsigned acc_m[MAXP][MAXP];
    longint unsigned tmp[MAXP][MAXP];
    longint unsigned sum;
    logic [SW-1:0] e;
    int top;
    parts = m1 & m2;
    top = 0;
    for (int k = 1; k <= MAXP; k++) begin
      if (parts[k-1]) top = k;
    end
    terms[0] = 1;
    for (int i = 1; i <= top; i++) begin
      sum = 0;
      for (int k = 1; k <= i; k++) begin
        if (parts[k-1]) sum = (sum + terms[i-k]) % PRIME;
      end
      terms[i] = sum;
    end
    if (n <= SW'(top)) return terms[n][VW-1:0];
    if (top == 0) return '0;
    for (int i = 0; i < top; i++) begin
      for (int k = 0; k < top; k++) begin
        pw[i][k] = (k == i + 1) ? 1 : 0;
        acc_m[i][k] = (i == k) ? 1 : 0;
      end
    end
    for (int k = 1; k <= top; k++) begin
      if (parts[k-1]) pw[top-1][top-k] = 1;
    end
    e = n - SW'(top);
    while (e != 0) begin
      if (e[0]) begin
        for (int r = 0; r < top; r++) begin
          for (int c = 0; c < top; c++) begin
            sum = 0;
            for (int k = 0; k < top; k++) sum = (sum + acc_m[r][k] * pw[k][c]) % PRIME;
            tmp[r][c] = sum;
          end
        end
        acc_m = tmp;
      end
      e = e >> 1;
      if (e != 0) begin
        for (int r = 0; r < top; r++) begin
          for (int c = 0; c < top; c++) begin
            sum = 0;
            for (int k = 0; k < top; k++) sum = (sum + pw[r][k] * pw[k][c]) % PRIME;
            tmp[r][c] = sum;
          end
        end
        pw = tmp;
      end
    end
    sum = 0;
    for (int k = 0; k < top; k++) sum = (sum + acc_m[top-1][k] * terms[k+1]) % PRIME;
    return sum[VW-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      counts_seen++;
      if (pending_ways.size() == 0) begin
        $error("way_count: unexpected result %0d", out_way_count);
        errors++;
      end else begin
        if (out_way_count !== pending_ways[0]) begin
          $error("way_count: expected %0d, actual %0d", pending_ways[0], out_way_count);
          errors++;
        end
        void'(pending_ways.pop_front());
      end
    end
  end

  // Leaves cfg_valid high; the caller lowers it after the last write of a burst.
  task automatic write_reg(input logic [IW-1:0] idx, input logic [MW-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    if (idx == rccm_pkg::REG_FIRST_SET) first_shadow = data;
    else if (idx == rccm_pkg::REG_SECOND_SET) second_shadow = data;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_ways.size() != 0 || busy) @(posedge clk);
    repeat (rccm_pkg::DRAIN_CYC + 2) @(posedge clk);
  endtask

  task automatic load_sets(input logic [MW-1:0] m1, input logic [MW-1:0] m2);
    settle();
    if ($urandom_range(0, 3) == 0) begin
      write_reg(IW'($urandom_range(2, 255)), {$urandom, $urandom});
    end
    write_reg(rccm_pkg::REG_FIRST_SET, m1);
    write_reg(rccm_pkg::REG_SECOND_SET, m2);
    cfg_valid <= 1'b0;
  endtask

  // Leaves start high; the caller either sends again or lowers it in the same step.
  task automatic send_sum(input logic [SW-1:0] n, input int gap, input bit known,
                          input logic [VW-1:0] ways);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_target_sum <= n;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_ways.push_back(known ? ways : count_ways(first_shadow, second_shadow, n));
    items_sent++;
  endtask

  function automatic row_t mk(input logic [MW-1:0] m1, input logic [MW-1:0] m2,
                              input logic [SW-1:0] n, input bit known,
                              input logic [VW-1:0] ways);
    row_t r;
    r.first_mask = m1;
    r.second_mask = m2;
    r.target = n;
    r.known = known;
    r.ways = ways;
    return r;
  endfunction

  function automatic logic [SW-1:0] pick_sum();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return SW'($urandom_range(0, 1000));
    if (sel < 8) return SW'($urandom);
    return SW'({$urandom, $urandom});
  endfunction

  initial begin
    int top;
    int gap;
    logic [MW-1:0] m1;
    logic [MW-1:0] m2;
    plan.push_back(mk('0, '0, '0, 1, 30'd1));
    plan.push_back(mk('0, '0, 60'd5, 1, 30'd0));
    plan.push_back(mk('0, '0, SUM_MAX, 1, 30'd0));
    plan.push_back(mk(ALL_ONES, ALL_ONES, 60'd0, 1, 30'd1));
    plan.push_back(mk(ALL_ONES, ALL_ONES, 60'd1, 1, 30'd1));
    plan.push_back(mk(ALL_ONES, ALL_ONES, 60'd2, 1, 30'd2));
    plan.push_back(mk(ALL_ONES, ALL_ONES, 60'd3, 1, 30'd4));
    plan.push_back(mk(ALL_ONES, ALL_ONES, 60'd64, 0, '0));
    plan.push_back(mk(ALL_ONES, ALL_ONES, 60'd65, 0, '0));
    plan.push_back(mk(64'h1, ALL_ONES, SUM_MAX, 1, 30'd1));
    plan.push_back(mk(64'h1, ALL_ONES, 60'd1000000000000000000, 1, 30'd1));
    plan.push_back(mk(64'h3, 64'h3, 60'd10, 1, 30'd89));
    plan.push_back(mk(64'h3, 64'h3, SUM_MAX, 0, '0));
    plan.push_back(mk(64'h5, 64'hA, 60'd0, 1, 30'd1));
    plan.push_back(mk(64'h5, 64'hA, 60'd7, 1, 30'd0));
    plan.push_back(mk(64'h8000_0000_0000_0000, ALL_ONES, 60'd64, 1, 30'd1));
    plan.push_back(mk(64'h8000_0000_0000_0000, ALL_ONES, 60'd63, 1, 30'd0));
    plan.push_back(mk(64'h8000_0000_0000_0000, ALL_ONES, 60'd0, 1, 30'd1));
    plan.push_back(mk(ALL_ONES, 64'h0FFF, 60'd1000, 0, '0));
    plan.push_back(mk(64'h2D, 64'h3F, 60'd12345, 0, '0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].first_mask !== first_shadow || plan[i].second_mask !== second_shadow) begin
        load_sets(plan[i].first_mask, plan[i].second_mask);
      end
      send_sum(plan[i].target, 0, plan[i].known, plan[i].ways);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 10 == 0) begin
        top = $urandom_range(1, 6);
        m1 = {$urandom, $urandom};
        m2 = {$urandom, $urandom};
        for (int b = top; b < MW; b++) m2[b] = m2[b] & ~m1[b];
        m1[top-1] = 1'b1;
        m2[top-1] = 1'b1;
        if ($urandom_range(0, 7) == 0) m2 = m2 & ~m1;
        load_sets(m1, m2);
      end
      gap = (i < N_RANDOM - 20 && $urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
      send_sum(pick_sum(), gap, 0, '0);
    end

    settle();
    $display("Sent %0d sums over %0d register writes; %0d counts checked.",
             items_sent, reg_writes, counts_seen);
    if (errors == 0) begin
      $display("restricted_composition_count_mod_tb OK");
    end else begin
      $display("restricted_composition_count_mod_tb NOT OK");
    end
    $finish;
  end

endmodule

### files.f
hdl/rccm_pkg.sv
hdl/rccm_modmul.sv
hdl/rccm_matmem.sv
hdl/restricted_composition_count_mod.sv
bench/restricted_composition_count_mod_tb.sv
